// ===== hdl/positional_ordered_list_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the positional ordered list.
// Each check reports through $error and is left out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ORDERED_LIST_MACROS_SVH
`define POSITIONAL_ORDERED_LIST_MACROS_SVH

`ifndef SYNTH

// Plain property, checked on every clock edge outside reset.
`define POL_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication in the same cycle.
`define POL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication in the following cycle.
`define POL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define POL_ASSERT(lbl, clk, rst_n, prop, msg)
`define POL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define POL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/pol_pkg.sv =====
// ----------------------------------------------------------------------------
// pol_pkg
// Types, codes and sizes shared by the positional ordered list modules.
// ----------------------------------------------------------------------------
package pol_pkg;

	localparam int CAPACITY   = 16;
	localparam int VALUE_BITS = 32;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CMP_W = ((CNT_W > 8) ? CNT_W : 8) + 1;

	localparam int OPCODE_W = 3;
	localparam int ITEM_W   = 32;
	localparam int POS_W    = 8;
	localparam int STATUS_W = 3;
	localparam int LEN_W    = 5;

	localparam int IN_DATA_W  = ((OPCODE_W + ITEM_W + POS_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((STATUS_W + ITEM_W + LEN_W + 7) / 8) * 8;

	typedef logic [VALUE_BITS-1:0] val_t;
	typedef logic [CAPACITY-1:0][VALUE_BITS-1:0] row_t;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_END   = 3'd1,
		OP_INS_POS   = 3'd2,
		OP_DEL_POS   = 3'd3,
		OP_DEL_FRONT = 3'd4,
		OP_DEL_END   = 3'd5,
		OP_DUMP      = 3'd6,
		OP_NOP       = 3'd7
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK     = 3'd0,
		STAT_BADPOS = 3'd1,
		STAT_BOUND  = 3'd2,
		STAT_FULL   = 3'd3,
		STAT_EMPTY  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INS  = 2'd1,
		CELL_DEL  = 2'd2,
		CELL_ROT  = 2'd3
	} cell_op_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		cell_op_t          op;
		logic [IDX_W-1:0]  idx;
		logic [CNT_W-1:0]  count;
		val_t              value;
	} cell_cmd_t;

	// Stored value to the 32-bit result field.
	function automatic logic [ITEM_W-1:0] to_out(input val_t v);
		return ITEM_W'(v);
	endfunction

endpackage

// ===== hdl/pol_cell.sv =====
// ----------------------------------------------------------------------------
// pol_cell
// One list cell: holds one entry and loads from its left or right neighbor,
// the new value, or the front cell when the list is rotated.
// ----------------------------------------------------------------------------
module pol_cell (
	input  logic                       clk,
	input  logic [pol_pkg::IDX_W-1:0]  my_idx,
	input  pol_pkg::cell_cmd_t         cmd,
	input  pol_pkg::val_t              left_val,
	input  pol_pkg::val_t              right_val,
	input  pol_pkg::val_t              wrap_val,
	output pol_pkg::val_t              val
);
	import pol_pkg::*;

	val_t             val_q;
	val_t             val_d;
	logic [CNT_W-1:0] my_pos;
	logic [CNT_W-1:0] cmd_pos;
	logic [CNT_W-1:0] my_next;

	assign my_pos  = CNT_W'(my_idx);
	assign cmd_pos = CNT_W'(cmd.idx);
	assign my_next = my_pos + CNT_W'(1);

	always_comb begin
		val_d = val_q;
		unique case (cmd.op)
			CELL_HOLD: val_d = val_q;
			CELL_INS: begin
				if (my_pos > cmd_pos) begin
					val_d = left_val;
				end else if (my_pos == cmd_pos) begin
					val_d = cmd.value;
				end
			end
			CELL_DEL: begin
				if (my_pos >= cmd_pos) begin
					val_d = right_val;
				end
			end
			CELL_ROT: begin
				// Only the occupied part of the chain turns; the last entry
				// closes the ring by taking the front value.
				if (my_next < cmd.count) begin
					val_d = right_val;
				end else if (my_next == cmd.count) begin
					val_d = wrap_val;
				end
			end
			default: val_d = val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

	assign val = val_q;

endmodule

// ===== hdl/pol_ctrl.sv =====
// ----------------------------------------------------------------------------
// pol_ctrl
// Decodes each input beat, checks it against the entry count, drives the
// cell chain and holds the result register.
// ----------------------------------------------------------------------------
`include "positional_ordered_list_macros.svh"

module pol_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pol_pkg::OPCODE_W-1:0]  opcode,
	input  logic signed [pol_pkg::ITEM_W-1:0] item_value,
	input  logic [pol_pkg::POS_W-1:0]     position,
	input  pol_pkg::row_t                 cells,
	output pol_pkg::cell_cmd_t            cmd,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pol_pkg::STATUS_W-1:0]  status,
	output logic [pol_pkg::ITEM_W-1:0]    out_value,
	output logic [pol_pkg::LEN_W-1:0]     list_length,
	output logic                          last
);
	import pol_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_DUMP = 2'b10
	} state_t;

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [CNT_W-1:0]    walk_q, walk_d;
	logic                valid_q;
	status_t             status_q;
	logic [ITEM_W-1:0]   value_q;
	logic [LEN_W-1:0]    len_q;
	logic                last_q;

	logic                out_free;
	logic                accept;
	op_t                 op;
	logic [CMP_W-1:0]    pos_ext;
	logic [CMP_W-1:0]    cnt_ext;
	logic [IDX_W-1:0]    pos_idx;
	logic                emit;
	status_t             e_status;
	logic [ITEM_W-1:0]   e_value;
	logic                e_last;

	assign out_free = !valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && out_free;
	assign accept   = in_valid && in_ready;
	assign op       = op_t'(opcode);
	assign pos_ext  = CMP_W'(position);
	assign cnt_ext  = CMP_W'(count_q);
	assign pos_idx  = IDX_W'(position - POS_W'(1));

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		walk_d    = walk_q;
		emit      = 1'b0;
		e_status  = STAT_OK;
		e_value   = '0;
		e_last    = 1'b1;
		cmd.op    = CELL_HOLD;
		cmd.idx   = '0;
		cmd.count = count_q;
		cmd.value = VALUE_BITS'(item_value);

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					emit = 1'b1;
					case (op) inside
						OP_INS_FRONT, OP_INS_END, OP_INS_POS: begin
							if (count_q == CNT_W'(CAPACITY)) begin
								e_status = STAT_FULL;
							end else if (op == OP_INS_POS && position == '0) begin
								e_status = STAT_BADPOS;
							end else if (op == OP_INS_POS &&
									pos_ext > cnt_ext + CMP_W'(1)) begin
								e_status = STAT_BOUND;
							end else begin
								cmd.op = CELL_INS;
								if (op == OP_INS_FRONT) begin
									cmd.idx = '0;
								end else if (op == OP_INS_END) begin
									cmd.idx = IDX_W'(count_q);
								end else begin
									cmd.idx = pos_idx;
								end
								count_d = count_q + CNT_W'(1);
							end
						end
						OP_DEL_POS, OP_DEL_FRONT, OP_DEL_END: begin
							if (count_q == '0) begin
								e_status = STAT_EMPTY;
							end else if (op == OP_DEL_POS && position == '0) begin
								e_status = STAT_BADPOS;
							end else if (op == OP_DEL_POS && pos_ext > cnt_ext) begin
								e_status = STAT_BOUND;
							end else begin
								cmd.op = CELL_DEL;
								if (op == OP_DEL_FRONT) begin
									cmd.idx = '0;
								end else if (op == OP_DEL_END) begin
									cmd.idx = IDX_W'(count_q - CNT_W'(1));
								end else begin
									cmd.idx = pos_idx;
								end
								e_value = to_out(cells[cmd.idx]);
								count_d = count_q - CNT_W'(1);
							end
						end
						OP_DUMP: begin
							if (count_q == '0) begin
								e_status = STAT_EMPTY;
							end else begin
								// The entries go out from the walk state.
								emit    = 1'b0;
								walk_d  = '0;
								state_d = S_DUMP;
							end
						end
						default: begin
							e_status = STAT_OK;
						end
					endcase
				end
			end
			S_DUMP: begin
				// The front entry goes out and the ring turns by one, so after
				// count beats the list is back in its original order.
				if (out_free) begin
					emit     = 1'b1;
					e_value  = to_out(cells[0]);
					cmd.op   = CELL_ROT;
					e_last   = (walk_q + CNT_W'(1)) == count_q;
					walk_d   = walk_q + CNT_W'(1);
					if (e_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			walk_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			walk_q  <= walk_d;
			if (emit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= e_status;
			value_q  <= e_value;
			len_q    <= LEN_W'(count_d);
			last_q   <= e_last;
		end
	end

	assign out_valid   = valid_q;
	assign status      = status_q;
	assign out_value   = value_q;
	assign list_length = len_q;
	assign last        = last_q;

	`POL_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
	`POL_ASSERT_IMP(a_dump_nonempty, clk, arst_n, state_q == S_DUMP, count_q != '0, "walking an empty list")
	`POL_ASSERT_NEXT(a_dump_count_stable, clk, arst_n, state_q == S_DUMP, count_q == $past(count_q), "entry count changed during a dump")
	`POL_ASSERT_NEXT(a_accept_answers, clk, arst_n, accept, valid_q || state_q == S_DUMP, "accepted beat left no result and no walk")
	`POL_ASSERT_IMP(a_walk_in_range, clk, arst_n, state_q == S_DUMP, walk_q < count_q, "dump walk beyond the last entry")

endmodule

// ===== hdl/positional_ordered_list.sv =====
// ----------------------------------------------------------------------------
// positional_ordered_list
// An insert, delete or no-op result is registered in the cycle after its
// beat is taken; one such beat per cycle while the result side keeps up.
// A dump sends one entry per cycle as the cell ring turns, while the result
// side keeps up. Reset clears the entry count and the control state at once;
// the cells are not cleared, since only occupied cells are ever read.
// ----------------------------------------------------------------------------
module positional_ordered_list (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// opcode [2:0], item_value [34:3], position [42:35], zero fill above
	input  logic [pol_pkg::IN_DATA_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// status [2:0], out_value [34:3], list_length [39:35]
	output logic [pol_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                            m_tlast
);
	import pol_pkg::*;

	localparam int VAL_LO = OPCODE_W;
	localparam int POS_LO = OPCODE_W + ITEM_W;

	logic [OPCODE_W-1:0]      opcode;
	logic signed [ITEM_W-1:0] item_value;
	logic [POS_W-1:0]         position;
	row_t                     cells;
	cell_cmd_t                cmd;
	logic [STATUS_W-1:0]      status;
	logic [ITEM_W-1:0]        out_value;
	logic [LEN_W-1:0]         list_length;

	assign opcode     = s_tdata[OPCODE_W-1:0];
	assign item_value = s_tdata[VAL_LO +: ITEM_W];
	assign position   = s_tdata[POS_LO +: POS_W];

	pol_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.opcode      (opcode),
		.item_value  (item_value),
		.position    (position),
		.cells       (cells),
		.cmd         (cmd),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.status      (status),
		.out_value   (out_value),
		.list_length (list_length),
		.last        (m_tlast)
	);

	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			val_t left_val;
			val_t right_val;

			if (i == 0) begin : g_first
				assign left_val = '0;
			end else begin : g_mid_l
				assign left_val = cells[i-1];
			end

			if (i == CAPACITY - 1) begin : g_last
				assign right_val = '0;
			end else begin : g_mid_r
				assign right_val = cells[i+1];
			end

			pol_cell u_cell (
				.clk       (clk),
				.my_idx    (IDX_W'(i)),
				.cmd       (cmd),
				.left_val  (left_val),
				.right_val (right_val),
				.wrap_val  (cells[0]),
				.val       (cells[i])
			);
		end
	endgenerate

	assign m_tdata = OUT_DATA_W'({list_length, out_value, status});

endmodule

// ===== bench/positional_ordered_list_checker.sv =====
// ----------------------------------------------------------------------------
// positional_ordered_list_checker
// Watches both stream channels of the positional ordered list. Each command
// beat taken on the slave side runs through a private copy of the list, and
// the results that the command should produce are queued. Each result beat
// taken on the master side is compared field by field with the oldest
// queued result.
// ----------------------------------------------------------------------------
module positional_ordered_list_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	// opcode [2:0], item_value [34:3], position [42:35], zero fill above
	input  logic [pol_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// status [2:0], out_value [34:3], list_length [39:35]
	input  logic [pol_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  logic                            m_tlast,
	output int                              mismatches,
	output int                              awaited
);
	import pol_pkg::*;

	typedef struct packed {
		status_t            status;
		logic [ITEM_W-1:0]  value;
		logic [LEN_W-1:0]   length;
		logic               last;
	} list_result_t;

	list_result_t pending_results[$];
	list_result_t want;
	val_t         cells [CAPACITY];
	int unsigned  used = 0;
	int           faults = 0;
	status_t      got_status;
	logic [ITEM_W-1:0] got_value;
	logic [LEN_W-1:0]  got_length;

	function automatic void post(input status_t st, input val_t v, input logic last);
		pending_results.push_back('{st, ITEM_W'(v), LEN_W'(used), last});
	endfunction

	function automatic void open_slot(input int unsigned idx, input val_t v);
		for (int unsigned i = used; i > idx; i--)
			cells[i] = cells[i-1];
		cells[idx] = v;
		used++;
	endfunction

	function automatic val_t close_slot(input int unsigned idx);
		val_t v;
		v = cells[idx];
		for (int unsigned i = idx; i + 1 < used; i++)
			cells[i] = cells[i+1];
		used--;
		return v;
	endfunction

	// Applies one command to the private list and queues its results.
	function automatic void predict_list_op(input op_t op, input logic [ITEM_W-1:0] raw,
			input logic [POS_W-1:0] pos);
		val_t v;
		v = val_t'($signed(raw));
		case (op)
		OP_INS_FRONT, OP_INS_END, OP_INS_POS: begin
			// A full list is reported before any position problem.
			if (used >= CAPACITY)
				post(STAT_FULL, '0, 1'b1);
			else if (op == OP_INS_FRONT) begin
				open_slot(0, v);
				post(STAT_OK, '0, 1'b1);
			end else if (op == OP_INS_END) begin
				open_slot(used, v);
				post(STAT_OK, '0, 1'b1);
			end else if (pos == 0)
				post(STAT_BADPOS, '0, 1'b1);
			else if (pos > used + 1)
				post(STAT_BOUND, '0, 1'b1);
			else begin
				open_slot(pos - 1, v);
				post(STAT_OK, '0, 1'b1);
			end
		end
		OP_DEL_POS, OP_DEL_FRONT, OP_DEL_END: begin
			if (used == 0)
				post(STAT_EMPTY, '0, 1'b1);
			else if (op == OP_DEL_FRONT)
				post(STAT_OK, close_slot(0), 1'b1);
			else if (op == OP_DEL_END)
				post(STAT_OK, close_slot(used - 1), 1'b1);
			else if (pos == 0)
				post(STAT_BADPOS, '0, 1'b1);
			else if (pos > used)
				post(STAT_BOUND, '0, 1'b1);
			else
				post(STAT_OK, close_slot(pos - 1), 1'b1);
		end
		OP_DUMP: begin
			if (used == 0)
				post(STAT_EMPTY, '0, 1'b1);
			else
				for (int unsigned i = 0; i < used; i++)
					post(STAT_OK, cells[i], i + 1 == used);
		end
		default: post(STAT_OK, '0, 1'b1);
		endcase
	endfunction

	always @(posedge clk) begin
		// Commands are handled first: a result beat taken at the same edge
		// always belongs to an older command.
		if (arst_n && s_tvalid && s_tready)
			predict_list_op(op_t'(s_tdata[OPCODE_W-1:0]), s_tdata[OPCODE_W +: ITEM_W],
				s_tdata[OPCODE_W+ITEM_W +: POS_W]);
		if (arst_n && m_tvalid && m_tready) begin
			got_status = status_t'(m_tdata[STATUS_W-1:0]);
			got_value  = m_tdata[STATUS_W +: ITEM_W];
			got_length = m_tdata[STATUS_W+ITEM_W +: LEN_W];
			if (pending_results.size() == 0) begin
				faults++;
				$display("%0t: unexpected result beat: expected none, got status %0d value %h length %0d last %b",
					$time, got_status, got_value, got_length, m_tlast);
			end else begin
				want = pending_results.pop_front();
				if (got_status != want.status) begin
					faults++;
					$display("%0t: status: expected %0d, got %0d", $time, want.status, got_status);
				end
				if (got_value != want.value) begin
					faults++;
					$display("%0t: out_value: expected %h, got %h", $time, want.value, got_value);
				end
				if (got_length != want.length) begin
					faults++;
					$display("%0t: list_length: expected %0d, got %0d", $time, want.length,
						got_length);
				end
				if (m_tlast != want.last) begin
					faults++;
					$display("%0t: last: expected %b, got %b", $time, want.last, m_tlast);
				end
			end
		end
		mismatches <= faults;
		awaited <= pending_results.size();
	end

endmodule

// ===== bench/positional_ordered_list_test.sv =====
// ----------------------------------------------------------------------------
// positional_ordered_list_test
// Drives the positional ordered list with a short directed sequence of edge
// cases, then with random commands that grow the list to full and drain it
// to empty over and over, with random gaps and stalls on both channels.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module positional_ordered_list_test;
	import pol_pkg::*;

	localparam int RANDOM_ITEMS   = 408;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 20;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic                   m_tlast;

	int          mismatch_total;
	int          open_results;
	int          sender_calm = 0;
	int          receiver_calm = 0;
	int unsigned recv_hold = 0;
	int unsigned fill = 0;
	int          quiet_cycles = 0;

	positional_ordered_list dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	positional_ordered_list_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.mismatches (mismatch_total),
		.awaited    (open_results)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Mostly a random wait per beat, with the odd stretch of back-to-back beats.
	function automatic int unsigned draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	task automatic send(input op_t op, input logic [ITEM_W-1:0] val, input logic [POS_W-1:0] pos);
		int unsigned gap;
		gap = draw_wait(sender_calm);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_DATA_W'({pos, val, op});
		do @(posedge clk); while (!s_tready);
		// Rough length tracking, used only to aim positions and steer growth.
		case (op)
		OP_INS_FRONT, OP_INS_END: if (fill < CAPACITY) fill++;
		OP_INS_POS: if (fill < CAPACITY && pos != 0 && pos <= fill + 1) fill++;
		OP_DEL_POS: if (fill != 0 && pos != 0 && pos <= fill) fill--;
		OP_DEL_FRONT, OP_DEL_END: if (fill != 0) fill--;
		default: ;
		endcase
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			recv_hold = draw_wait(receiver_calm);
			m_tready <= (recv_hold == 0);
		end else if (recv_hold != 0) begin
			recv_hold = recv_hold - 1;
			m_tready <= (recv_hold == 0);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		op_t               op;
		logic [ITEM_W-1:0] val;
		logic [POS_W-1:0]  pos;
		int                roll;
		int                kind;
		bit                adding;
		bit                grow;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Everything that can be refused while the list is empty, and a no-op.
		send(OP_DUMP, '0, '0);
		send(OP_DEL_FRONT, '0, '0);
		send(OP_DEL_END, '0, '0);
		send(OP_DEL_POS, '0, 8'd1);
		send(OP_INS_POS, 32'h1234_5678, 8'd2);
		send(OP_INS_POS, 32'h1234_5678, 8'd0);
		send(OP_NOP, 32'hFFFF_FFFF, 8'hFF);
		// Build a short list from the value extremes.
		send(OP_INS_FRONT, 32'h8000_0000, '0);
		send(OP_INS_END, 32'h7FFF_FFFF, '0);
		send(OP_INS_POS, 32'hFFFF_FFFF, 8'd2);
		send(OP_INS_POS, 32'h0000_0000, 8'd4);
		send(OP_INS_POS, 32'h0000_0001, 8'd6);
		send(OP_INS_POS, 32'h0000_0001, 8'd255);
		send(OP_DUMP, '0, '0);
		send(OP_DEL_POS, '0, 8'd0);
		send(OP_DEL_POS, '0, 8'd5);
		send(OP_DEL_POS, '0, 8'd255);
		send(OP_DEL_POS, '0, 8'd2);
		send(OP_DEL_FRONT, '0, '0);
		send(OP_DEL_END, '0, '0);
		send(OP_INS_POS, 32'h5A5A_A5A5, 8'd1);
		send(OP_DEL_POS, '0, 8'd1);

		grow = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Stay at full or empty for a while before turning around, so that
			// inserts into a full list and deletes from an empty one happen.
			if (grow && fill == CAPACITY && $urandom_range(0, 3) == 0)
				grow = 1'b0;
			else if (!grow && fill == 0 && $urandom_range(0, 3) == 0)
				grow = 1'b1;
			else if ($urandom_range(0, 49) == 0)
				grow = !grow;

			roll = $urandom_range(0, 99);
			if (roll < 78) begin
				kind = $urandom_range(0, 3);
				adding = grow ? (roll < 60) : (roll < 18);
				case (kind)
				0, 1: op = adding ? OP_INS_POS : OP_DEL_POS;
				2: op = adding ? OP_INS_FRONT : OP_DEL_FRONT;
				default: op = adding ? OP_INS_END : OP_DEL_END;
				endcase
			end else if (roll < 97)
				op = OP_DUMP;
			else
				op = OP_NOP;

			case ($urandom_range(0, 9))
			0: val = 32'h8000_0000;
			1: val = 32'h7FFF_FFFF;
			2: val = '1;
			3: val = '0;
			default: val = $urandom;
			endcase

			if ($urandom_range(0, 6) == 0)
				pos = POS_W'($urandom_range(0, 255));
			else if (op == OP_INS_POS)
				pos = POS_W'($urandom_range(1, fill + 1));
			else
				pos = (fill == 0) ? 8'd1 : POS_W'($urandom_range(1, fill));

			send(op, val, pos);
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (open_results != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_total == 0 && open_results == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
